[hdl/wlrs_pkg.sv]
// wlrs_pkg: shared constants, codes and controller/datapath interface types
// for the wear-leveling ring store; depends on nothing
`default_nettype none

package wlrs_pkg;

    // parameter defaults
    localparam int DEF_MAX_SLOTS  = 16;
    localparam int DEF_MAX_PACKET = 16;

    // fixed field widths
    localparam int BYTE_W       = 8;
    localparam int SLOT_FIELD_W = 4;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_SIZE = 1'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_SLOT_COUNT  = 5'd16;
    localparam logic [CFG_W-1:0] RST_PACKET_SIZE = 5'd16;

    // request function codes
    localparam logic FUNC_SAVE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // latch the request, restart the status scan
        logic scan_step;  // advance the status scan by one entry
        logic take_slot;  // scan finished for a save: pick slot, wrap if full
        logic take_read;  // scan finished for a read: pick latest slot
        logic save_byte;  // write the byte, present the save acknowledge
        logic rd_issue;   // read the current packet byte from the store
        logic rd_next;    // read the following packet byte, advance index
        logic rd_emit;    // present the read byte
        logic emit_empty; // present the empty result
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic req_func;   // function of the latched request
        logic save_open;  // a packet save is part way through
        logic scan_hit;   // current status entry is free
        logic scan_end;   // current status entry is the last one of the ring
        logic scan_first; // scan is at entry zero
        logic out_free;   // output register can take a result this cycle
        logic rd_last;    // byte being read is the final one of the packet
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/wlrs_ram.sv]
// wlrs_ram: generic simple dual-port RAM, one write and one registered read
// port; no dependencies
`default_nettype none

module wlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/wlrs_datapath.sv]
// wlrs_datapath: configuration registers, status bits, scan and byte
// counters, packet store and output register; uses wlrs_pkg and wlrs_ram
`default_nettype none

module wlrs_datapath #(
    parameter int MAX_SLOTS  = wlrs_pkg::DEF_MAX_SLOTS,
    parameter int MAX_PACKET = wlrs_pkg::DEF_MAX_PACKET
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire wlrs_pkg::ctl_cmd_t                  cmd,
    output wlrs_pkg::dp_stat_t                       stat,
    input  wire logic                                func,
    input  wire logic [wlrs_pkg::BYTE_W-1:0]         data_byte,
    input  wire logic                                cfg_we,
    input  wire logic [wlrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wlrs_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic      [wlrs_pkg::BYTE_W-1:0]         out_byte,
    output logic                                     last,
    output logic                                     empty_res,
    output logic      [wlrs_pkg::SLOT_FIELD_W-1:0]   slot,
    output logic                                     wrapped
);

    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW    = $clog2(MAX_SLOTS + 1);
    localparam int PW    = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
    localparam int PW1   = $clog2(MAX_PACKET + 1);
    localparam int DEPTH = MAX_SLOTS * MAX_PACKET;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration and control state
    logic [wlrs_pkg::CFG_W-1:0] slot_count_reg, slot_count_next;
    logic [wlrs_pkg::CFG_W-1:0] packet_size_reg, packet_size_next;
    logic [MAX_SLOTS-1:0]       used_reg, used_next;
    logic [SW-1:0]              scan_idx_reg, scan_idx_next;
    logic [SW-1:0]              save_slot_reg, save_slot_next;
    logic [PW-1:0]              save_cnt_reg, save_cnt_next;
    logic                       wrap_reg, wrap_next;
    logic                       out_valid_reg, out_valid_next;

    // payload state
    logic                          func_reg;
    logic [wlrs_pkg::BYTE_W-1:0]   data_reg;
    logic [SW-1:0]                 rd_slot_reg;
    logic [PW-1:0]                 rd_idx_reg;
    logic [wlrs_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;
    logic [wlrs_pkg::SLOT_FIELD_W-1:0] out_slot_reg;
    logic                          out_wrap_reg;

    logic [NW-1:0]  eff_n;
    logic [PW1-1:0] eff_ps;
    logic           scan_hit;
    logic           scan_end;
    logic           save_last;
    logic           rd_last;
    logic           out_free;
    logic           out_load;
    logic [PW-1:0]  rd_addr_idx;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [wlrs_pkg::BYTE_W-1:0] rdata;

    // saturate configuration to the supported ranges
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            eff_n = NW'(1);
        end
        else if (int'(slot_count_reg) > MAX_SLOTS)
        begin
            eff_n = NW'(MAX_SLOTS);
        end
        else
        begin
            eff_n = NW'(slot_count_reg);
        end
        if (packet_size_reg == '0)
        begin
            eff_ps = PW1'(1);
        end
        else if (int'(packet_size_reg) > MAX_PACKET)
        begin
            eff_ps = PW1'(MAX_PACKET);
        end
        else
        begin
            eff_ps = PW1'(packet_size_reg);
        end
    end

    // scan and end-of-packet conditions
    assign scan_hit  = !used_reg[scan_idx_reg];
    assign scan_end  = (NW'(scan_idx_reg) + NW'(1)) >= eff_n;
    assign save_last = (PW1'(save_cnt_reg) + PW1'(1)) >= eff_ps;
    assign rd_last   = (PW1'(rd_idx_reg) + PW1'(1)) >= eff_ps;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = cmd.save_byte || cmd.rd_emit || cmd.emit_empty;

    assign stat.req_func   = func_reg;
    assign stat.save_open  = (save_cnt_reg != '0);
    assign stat.scan_hit   = scan_hit;
    assign stat.scan_end   = scan_end;
    assign stat.scan_first = (scan_idx_reg == '0);
    assign stat.out_free   = out_free;
    assign stat.rd_last    = rd_last;

    // next-state logic of the control registers
    always_comb
    begin
        slot_count_next  = slot_count_reg;
        packet_size_next = packet_size_reg;
        used_next        = used_reg;
        scan_idx_next    = scan_idx_reg;
        save_slot_next   = save_slot_reg;
        save_cnt_next    = save_cnt_reg;
        wrap_next        = wrap_reg;
        out_valid_next   = out_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                wlrs_pkg::REG_SLOT_COUNT:  slot_count_next  = cfg_data;
                wlrs_pkg::REG_PACKET_SIZE: packet_size_next = cfg_data;
                default:                   slot_count_next  = slot_count_reg;
            endcase
        end

        if (cmd.accept)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + SW'(1);
        end

        // slot choice; a full ring clears the status entries in use
        if (cmd.take_slot)
        begin
            wrap_next = !scan_hit;
            if (scan_hit)
            begin
                save_slot_next = scan_idx_reg;
            end
            else
            begin
                save_slot_next = '0;
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (NW'(i) < eff_n)
                    begin
                        used_next[i] = 1'b0;
                    end
                end
            end
        end

        // byte save; the final byte marks the slot used
        if (cmd.save_byte)
        begin
            wrap_next = 1'b0;
            if (save_last)
            begin
                save_cnt_next            = '0;
                used_next[save_slot_reg] = 1'b1;
            end
            else
            begin
                save_cnt_next = save_cnt_reg + PW'(1);
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= wlrs_pkg::RST_SLOT_COUNT;
            packet_size_reg <= wlrs_pkg::RST_PACKET_SIZE;
            used_reg        <= '0;
            scan_idx_reg    <= '0;
            save_slot_reg   <= '0;
            save_cnt_reg    <= '0;
            wrap_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            slot_count_reg  <= slot_count_next;
            packet_size_reg <= packet_size_next;
            used_reg        <= used_next;
            scan_idx_reg    <= scan_idx_next;
            save_slot_reg   <= save_slot_next;
            save_cnt_reg    <= save_cnt_next;
            wrap_reg        <= wrap_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request latch, read pointer and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            data_reg <= data_byte;
        end
        if (cmd.take_read)
        begin
            rd_slot_reg <= scan_hit ? (scan_idx_reg - SW'(1)) : scan_idx_reg;
            rd_idx_reg  <= '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_reg <= rd_idx_reg + PW'(1);
        end
        if (cmd.save_byte)
        begin
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b0;
            out_slot_reg  <= wlrs_pkg::SLOT_FIELD_W'(save_slot_reg);
            out_wrap_reg  <= wrap_reg;
        end
        else if (cmd.rd_emit)
        begin
            out_byte_reg  <= rdata;
            out_last_reg  <= rd_last;
            out_empty_reg <= 1'b0;
            out_slot_reg  <= wlrs_pkg::SLOT_FIELD_W'(rd_slot_reg);
            out_wrap_reg  <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
            out_slot_reg  <= '0;
            out_wrap_reg  <= 1'b0;
        end
    end

    // packet store addressing
    assign rd_addr_idx = cmd.rd_next ? (rd_idx_reg + PW'(1)) : rd_idx_reg;
    assign waddr = AW'(save_slot_reg) * AW'(MAX_PACKET) + AW'(save_cnt_reg);
    assign raddr = AW'(rd_slot_reg) * AW'(MAX_PACKET) + AW'(rd_addr_idx);

    wlrs_ram #(
        .WIDTH (wlrs_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_packet_ram (
        .clk   (clk),
        .we    (cmd.save_byte),
        .waddr (waddr),
        .wdata (data_reg),
        .re    (cmd.rd_issue || cmd.rd_next),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;
    assign slot      = out_slot_reg;
    assign wrapped   = out_wrap_reg;

endmodule

`default_nettype wire

[hdl/wlrs_ctrl.sv]
// wlrs_ctrl: request sequencer for scan, save and packet read-back;
// uses wlrs_pkg
`default_nettype none

module wlrs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire wlrs_pkg::dp_stat_t stat,
    output wlrs_pkg::ctl_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_SAVE    = 3'd2;
    localparam logic [2:0] ST_RD_ADDR = 3'd3;
    localparam logic [2:0] ST_RD_DATA = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    logic [2:0] state_reg, state_next;

    // state transitions and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (func == wlrs_pkg::FUNC_SAVE && stat.save_open)
                    begin
                        state_next = ST_SAVE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_hit || stat.scan_end)
                begin
                    if (stat.req_func == wlrs_pkg::FUNC_SAVE)
                    begin
                        cmd.take_slot = 1'b1;
                        state_next    = ST_SAVE;
                    end
                    else if (stat.scan_hit && stat.scan_first)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.take_read = 1'b1;
                        state_next    = ST_RD_ADDR;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SAVE:
            begin
                if (stat.out_free)
                begin
                    cmd.save_byte = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/wear_leveling_ring_store_top.sv]
// wear_leveling_ring_store_top: wear-leveling packet ring store, top level
// uses wlrs_pkg, wlrs_ctrl, wlrs_datapath (and through it wlrs_ram)
//
//   channel   signals                                          transfer
//   -------   ----------------------------------------------   ----------------
//   input     in_valid / in_ready, func, data_byte             valid & ready
//   output    out_valid / out_ready, out_byte, last,           valid & ready
//             empty_res, slot, wrapped
//   config    cfg_we, cfg_index, cfg_data                      cfg_we, no wait
//
// sequence: a save byte that continues a packet is stored directly; a first save
// byte scans the status entries first (1..slot_count); a read scans, then emits
// packet_size bytes, one per cycle unless output stalls; an empty store reports empty.
// reset: asynchronous, clears status bits and counters; packet store not cleared
// stalls: a held output register stops the sequencer; the next request is
// taken once the previous one's results are all loaded into the output.
`default_nettype none

module wear_leveling_ring_store_top #(
    parameter int MAX_SLOTS  = wlrs_pkg::DEF_MAX_SLOTS,
    parameter int MAX_PACKET = wlrs_pkg::DEF_MAX_PACKET
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [wlrs_pkg::BYTE_W-1:0]         data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [wlrs_pkg::BYTE_W-1:0]         out_byte,
    output logic                                     last,
    output logic                                     empty_res,
    output logic      [wlrs_pkg::SLOT_FIELD_W-1:0]   slot,
    output logic                                     wrapped,
    input  wire logic                                cfg_we,
    input  wire logic [wlrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wlrs_pkg::CFG_W-1:0]          cfg_data
);

    wlrs_pkg::ctl_cmd_t cmd;
    wlrs_pkg::dp_stat_t stat;

    // sequencer
    wlrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and output register
    wlrs_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_PACKET (MAX_PACKET)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .empty_res (empty_res),
        .slot      (slot),
        .wrapped   (wrapped)
    );

endmodule

`default_nettype wire

[hdl/wlrs_checker.sv]
// wlrs_checker: port-level checks of the ring store, bound to the top level
// uses wlrs_pkg for field widths
`default_nettype none

module wlrs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [wlrs_pkg::BYTE_W-1:0]       out_byte,
    input wire logic                              last,
    input wire logic                              empty_res,
    input wire logic [wlrs_pkg::SLOT_FIELD_W-1:0] slot,
    input wire logic                              wrapped
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
            && $stable(slot) && $stable(empty_res) && $stable(wrapped))
        else $error("result changed while stalled");

    // an accepted request keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a request");

    // the empty answer is a single, otherwise blank result
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && out_byte == '0 && slot == '0 && !wrapped)
        else $error("malformed empty result");

    // a wrap is reported only on a save acknowledge for slot zero
    a_wrap_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrapped |-> last && !empty_res && out_byte == '0 && slot == '0)
        else $error("malformed wrap result");

endmodule

bind wear_leveling_ring_store_top wlrs_checker u_wlrs_checker (.*);

`default_nettype wire
